FILE: hdl/tensor_pack_to_hwc_u8_assert.svh
// Assertion macros shared by the tensor_pack_to_hwc_u8 RTL.
// Requires nothing else; included by files that carry assertions.
`ifndef TENSOR_PACK_TO_HWC_U8_ASSERT_SVH
`define TENSOR_PACK_TO_HWC_U8_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPHWC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPHWC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/tphwc_pkg.sv
// Shared constants and types for the tensor_pack_to_hwc_u8 block.
// No dependencies.
package tphwc_pkg;

    localparam int unsigned MAX_HEIGHT   = 4096;
    localparam int unsigned MAX_WIDTH    = 4096;
    localparam int unsigned MAX_CHANNELS = 16;

    localparam int unsigned DIM_W   = 13;
    localparam int unsigned CDIM_W  = 5;
    localparam int unsigned POS_W   = 12;
    localparam int unsigned CPOS_W  = 4;
    localparam int unsigned DEST_W  = 28;
    localparam int unsigned ELEM_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned MTDATA_W = 40;
    localparam int unsigned PADDR_W = 5;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

    typedef enum logic [2:0] {
        REG_FRAME_HEIGHT    = 3'd0,
        REG_FRAME_WIDTH     = 3'd1,
        REG_CHANNEL_COUNT   = 3'd2,
        REG_SOURCE_PLANAR   = 3'd3,
        REG_SOURCE_IS_FLOAT = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [ELEM_W-1:0] element_bits;
        logic [DEST_W-1:0] dest_index;
        logic              last_element;
    } stage_t;

endpackage

FILE: hdl/tphwc_float_cvt.sv
// Element to byte conversion: uint8 passthrough or float32 round and clamp.
// Depends on tphwc_pkg.
module tphwc_float_cvt (
    input  logic [tphwc_pkg::ELEM_W-1:0] element_bits,
    input  logic                         is_float,
    output logic [tphwc_pkg::BYTE_W-1:0] pixel_byte
);
    import tphwc_pkg::*;

    logic        sign;
    logic [7:0]  expo;
    logic [22:0] mant;
    logic [23:0] mant_full;
    logic [3:0]  shm1;
    logic [8:0]  trunc;
    logic [9:0]  rounded;
    logic [BYTE_W-1:0] fbyte;

    assign sign      = element_bits[31];
    assign expo      = element_bits[30:23];
    assign mant      = element_bits[22:0];
    assign mant_full = {1'b1, mant};
    // The shift minus one (15 plus shm1) lies in 15..23 for exponents 126..134.
    assign shm1      = 4'(8'd149 - expo - 8'd15);
    assign trunc     = 9'(mant_full >> (5'd15 + {1'b0, shm1}));
    assign rounded   = ({1'b0, trunc} + 10'd1) >> 1;

    always_comb begin
        if (expo == 8'hFF) begin
            fbyte = (mant != 23'd0 || sign) ? '0 : BYTE_MAX;
        end else if (sign || expo < 8'd126) begin
            fbyte = '0;
        end else if (expo >= 8'd135 || rounded > 10'(BYTE_MAX)) begin
            fbyte = BYTE_MAX;
        end else begin
            fbyte = rounded[BYTE_W-1:0];
        end
    end

    assign pixel_byte = is_float ? fbyte : element_bits[BYTE_W-1:0];

endmodule

FILE: hdl/tensor_pack_to_hwc_u8.sv
// Tensor stream packer: reorders CHW or HWC elements into HWC byte addresses.
// Depends on tphwc_pkg, tphwc_float_cvt and tensor_pack_to_hwc_u8_assert.svh.
//
// Usage: program the dimensions, source order and element type over the
// APB port while the stream is idle; any register write restarts the tensor.
// Each word on the s_ channel is one source element. Each word on the m_
// channel carries the element's HWC byte address and converted byte, with
// m_tlast set on the final element of the tensor, after which the position
// counters wrap and the next word starts a new tensor.
// A word passes two register stages, input then output, and m_tvalid rises
// once it reaches the output stage. One word is taken every cycle while the
// receiver does not stall: position counters advance incrementally in the
// input stage, and the float rounding sits between the input register and
// the output register. When the receiver stalls, the two stages fill and
// s_tready drops; no word is lost. Reset clears the registers to one row,
// one column, one channel, interleaved uint8, and empties both stages.
module tensor_pack_to_hwc_u8 (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tphwc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tphwc_pkg::ELEM_W-1:0]    s_tdata,   // element_bits[31:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tphwc_pkg::MTDATA_W-1:0]  m_tdata,   // dest_index[27:0], pixel_byte[35:28]
    output logic                            m_tlast
);
    import tphwc_pkg::*;

    `include "tensor_pack_to_hwc_u8_assert.svh"

    logic [DIM_W-1:0]  frame_height_reg, frame_width_reg;
    logic [CDIM_W-1:0] channel_count_reg;
    logic              source_planar_reg, source_is_float_reg;
    logic [DIM_W-1:0]  h_eff, w_eff;
    logic [CDIM_W-1:0] c_eff;
    logic              cfg_wr, cfg_hit;
    reg_idx_t          cfg_idx;

    logic [CPOS_W-1:0] chan_reg, chan_next;
    logic [POS_W-1:0]  row_reg, row_next, col_reg, col_next;
    logic [DEST_W-1:0] dest_reg, dest_next;
    logic              chan_end, row_end, col_end, last_now;

    stage_t            s1_reg;
    logic              s1_valid_reg;
    logic              m_valid_reg;
    logic [DEST_W-1:0] m_dest_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic              m_last_reg;
    logic [BYTE_W-1:0] cvt_byte;
    logic              advance, s_accept;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_hit = cfg_wr && (cfg_idx inside {REG_FRAME_HEIGHT, REG_FRAME_WIDTH,
                                                REG_CHANNEL_COUNT, REG_SOURCE_PLANAR,
                                                REG_SOURCE_IS_FLOAT});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_height_reg    <= DIM_W'(1);
            frame_width_reg     <= DIM_W'(1);
            channel_count_reg   <= CDIM_W'(1);
            source_planar_reg   <= 1'b0;
            source_is_float_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FRAME_HEIGHT:    frame_height_reg    <= pwdata[DIM_W-1:0];
                REG_FRAME_WIDTH:     frame_width_reg     <= pwdata[DIM_W-1:0];
                REG_CHANNEL_COUNT:   channel_count_reg   <= pwdata[CDIM_W-1:0];
                REG_SOURCE_PLANAR:   source_planar_reg   <= pwdata[0];
                REG_SOURCE_IS_FLOAT: source_is_float_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_FRAME_HEIGHT:    prdata = 32'(frame_height_reg);
            REG_FRAME_WIDTH:     prdata = 32'(frame_width_reg);
            REG_CHANNEL_COUNT:   prdata = 32'(channel_count_reg);
            REG_SOURCE_PLANAR:   prdata = 32'(source_planar_reg);
            REG_SOURCE_IS_FLOAT: prdata = 32'(source_is_float_reg);
            default:             prdata = '0;
        endcase
    end

    // A zero dimension acts as one and an oversized one as the maximum.
    assign h_eff = (frame_height_reg == '0) ? DIM_W'(1) :
                   (frame_height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                           : frame_height_reg;
    assign w_eff = (frame_width_reg == '0) ? DIM_W'(1) :
                   (frame_width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                         : frame_width_reg;
    assign c_eff = (channel_count_reg == '0) ? CDIM_W'(1) :
                   (channel_count_reg > CDIM_W'(MAX_CHANNELS)) ? CDIM_W'(MAX_CHANNELS)
                                                               : channel_count_reg;

    assign chan_end = ({1'b0, chan_reg} == c_eff - CDIM_W'(1));
    assign row_end  = ({1'b0, row_reg} == h_eff - DIM_W'(1));
    assign col_end  = ({1'b0, col_reg} == w_eff - DIM_W'(1));
    assign last_now = chan_end && row_end && col_end;

    always_comb begin
        chan_next = chan_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        dest_next = dest_reg;
        if (source_planar_reg) begin
            if (!col_end) begin
                col_next  = col_reg + POS_W'(1);
                dest_next = dest_reg + DEST_W'(c_eff);
            end else if (!row_end) begin
                col_next  = '0;
                row_next  = row_reg + POS_W'(1);
                dest_next = dest_reg + DEST_W'(c_eff);
            end else begin
                col_next  = '0;
                row_next  = '0;
                chan_next = chan_end ? '0 : chan_reg + CPOS_W'(1);
                dest_next = chan_end ? '0 : DEST_W'(chan_reg) + DEST_W'(1);
            end
        end else begin
            dest_next = last_now ? '0 : dest_reg + DEST_W'(1);
            if (!chan_end) begin
                chan_next = chan_reg + CPOS_W'(1);
            end else begin
                chan_next = '0;
                if (!col_end) begin
                    col_next = col_reg + POS_W'(1);
                end else begin
                    col_next = '0;
                    row_next = row_end ? '0 : row_reg + POS_W'(1);
                end
            end
        end
    end

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance || !s1_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            chan_reg <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            dest_reg <= '0;
        end else if (s_accept) begin
            chan_reg <= chan_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            dest_reg <= dest_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_reg.element_bits <= s_tdata;
            s1_reg.dest_index   <= dest_reg;
            s1_reg.last_element <= last_now;
        end
        if (advance && s1_valid_reg) begin
            m_dest_reg <= s1_reg.dest_index;
            m_byte_reg <= cvt_byte;
            m_last_reg <= s1_reg.last_element;
        end
    end

    tphwc_float_cvt u_cvt (
        .element_bits (s1_reg.element_bits),
        .is_float     (source_is_float_reg),
        .pixel_byte   (cvt_byte)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_byte_reg, m_dest_reg};
    assign m_tlast  = m_last_reg;

    `TPHWC_ASSERT_NEXT(a_cfg_restart, aclk, aresetn, cfg_hit,
        dest_reg == '0 && chan_reg == '0 && row_reg == '0 && col_reg == '0)
    `TPHWC_ASSERT_NEXT(a_wrap_after_last, aclk, aresetn, s_accept && last_now && !cfg_hit,
        dest_reg == '0 && chan_reg == '0 && row_reg == '0 && col_reg == '0)
    `TPHWC_ASSERT_NEXT(a_hwc_step, aclk, aresetn,
        s_accept && !last_now && !source_planar_reg && !cfg_hit,
        dest_reg == $past(dest_reg) + DEST_W'(1))
    `TPHWC_ASSERT_NEXT(a_stage_held, aclk, aresetn, s1_valid_reg && !advance,
        s1_valid_reg && $stable(s1_reg))

endmodule
